// ===== rtl/opmb_pkg.sv =====
// ----------------------------------------------------------------------------
// Outer-product matmul block: shared definitions
// Widths, tile shape, data types and the control group between the top level
// and the row cells.
// ----------------------------------------------------------------------------
package opmb_pkg;

    localparam int TILE_ROWS  = 4;
    localparam int TILE_LANES = 4;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 48;
    localparam int CFG_W      = 3;
    localparam int ROW_W      = 2;
    localparam int CNT_W      = 3;

    localparam logic [CFG_W-1:0] ACTIVE_COLUMNS_RESET = CFG_W'(4);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef t_data t_data_lanes [TILE_LANES];
    typedef t_acc  t_acc_row    [TILE_LANES];

    // Control shared by every row cell in a cycle.
    typedef struct packed {
        logic step;   // an item is accepted this cycle
        logic last;   // the accepted item closes the tile
        logic shift;  // the head result is taken, results move one cell down
    } t_cell_ctl;

endpackage

// ===== rtl/opmb_ifs.sv =====
// ----------------------------------------------------------------------------
// Outer-product matmul block: channel interfaces
// Input step channel, result channel and configuration write channel, each
// with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface opmb_in_if;
    import opmb_pkg::*;

    logic  valid;
    logic  ready;
    t_data a_row0;
    t_data a_row1;
    t_data a_row2;
    t_data a_row3;
    t_data b_lane0;
    t_data b_lane1;
    t_data b_lane2;
    t_data b_lane3;
    logic  last_step;

    modport source (
        output valid, a_row0, a_row1, a_row2, a_row3,
               b_lane0, b_lane1, b_lane2, b_lane3, last_step,
        input  ready
    );
    modport sink (
        input  valid, a_row0, a_row1, a_row2, a_row3,
               b_lane0, b_lane1, b_lane2, b_lane3, last_step,
        output ready
    );
endinterface

interface opmb_out_if;
    import opmb_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] tile_row;
    t_acc             c_lane0;
    t_acc             c_lane1;
    t_acc             c_lane2;
    t_acc             c_lane3;
    logic             last_row;

    modport source (
        output valid, tile_row, c_lane0, c_lane1, c_lane2, c_lane3, last_row,
        input  ready
    );
    modport sink (
        input  valid, tile_row, c_lane0, c_lane1, c_lane2, c_lane3, last_row,
        output ready
    );
endinterface

interface opmb_cfg_if;
    import opmb_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/opmb_cell.sv =====
// ----------------------------------------------------------------------------
// Outer-product matmul block: row cell
// Holds the accumulators of one tile row and one stage of the result chain.
// On the closing step it loads its final sums into the chain and clears.
// ----------------------------------------------------------------------------
module opmb_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  opmb_pkg::t_cell_ctl            i_ctl,
    input  logic [opmb_pkg::TILE_LANES-1:0] i_lane_mask,
    input  opmb_pkg::t_data                i_a,
    input  opmb_pkg::t_data_lanes          i_b,
    input  opmb_pkg::t_acc_row             i_drain_next,
    output opmb_pkg::t_acc_row             o_drain
);
    import opmb_pkg::*;

    t_acc_row r_acc;
    t_acc_row n_acc;
    t_acc_row r_drain;
    t_acc_row n_drain;
    t_prod    prod [TILE_LANES];
    t_acc_row sum;

    always_comb begin
        for (int l = 0; l < TILE_LANES; l++) begin
            prod[l] = PROD_W'(i_a) * PROD_W'(i_b[l]);
            sum[l]  = r_acc[l] + ACC_W'(prod[l]);
        end
    end

    always_comb begin
        n_acc   = r_acc;
        n_drain = r_drain;
        if (i_ctl.step) begin
            for (int l = 0; l < TILE_LANES; l++) begin
                if (i_ctl.last) begin
                    n_acc[l]   = '0;
                    n_drain[l] = i_lane_mask[l] ? sum[l] : '0;
                end else if (i_lane_mask[l]) begin
                    n_acc[l] = sum[l];
                end
            end
        end
        // A closing step is only taken with the chain empty, so it never
        // meets a shift.
        if (i_ctl.shift && !(i_ctl.step && i_ctl.last)) begin
            n_drain = i_drain_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < TILE_LANES; l++) begin
                r_acc[l] <= '0;
            end
        end else begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_drain <= n_drain;
    end

    assign o_drain = r_drain;

endmodule

// ===== rtl/outer_product_matmul_block_unit.sv =====
// ----------------------------------------------------------------------------
// Outer-product matmul block
// 4 x 4 register-blocked matrix multiply tile with Q4.12 operands and
// 48-bit Q24.24 accumulators.
// ----------------------------------------------------------------------------
// Each input item is one step along the shared dimension: when it is
// accepted, four row cells each multiply their A value by the four B lanes
// and add into their accumulators, so ordinary steps stream at one item per
// clock. The step marked last is folded in, its four rows are copied into
// the cells' result stages and the accumulators clear, so the next tile may
// start in the following cycle. The result stages form a chain that hands
// one row per accepted result to the output, row 0 first; a tile therefore
// yields four result rows, and a closing step is held off until the
// previous tile's rows are all taken. Lanes at or above active_columns are
// neither accumulated nor reported (they read zero). Configuration is taken
// at any time, but is meant to be written while the block is idle.
module outer_product_matmul_block_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    opmb_in_if.sink         i_in,
    opmb_out_if.source      o_out,
    opmb_cfg_if.sink        i_cfg
);
    import opmb_pkg::*;

    logic [CFG_W-1:0]      r_active_columns;
    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      n_left;
    logic [TILE_LANES-1:0] lane_mask;
    t_cell_ctl             cell_ctl;
    t_data                 a_rows [TILE_ROWS];
    t_data_lanes           b_lanes;
    t_acc_row              drain [TILE_ROWS+1];
    logic                  accept;
    logic                  pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_columns <= ACTIVE_COLUMNS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_active_columns <= i_cfg.data;
        end
    end

    always_comb begin
        for (int l = 0; l < TILE_LANES; l++) begin
            lane_mask[l] = r_active_columns > CFG_W'(l);
        end
    end

    // Ordinary steps are always taken; a closing step waits for an empty chain.
    assign i_in.ready = !i_in.last_step || (r_left == '0);
    assign accept     = i_in.valid && i_in.ready;
    assign pop        = o_out.valid && o_out.ready;

    assign cell_ctl.step  = accept;
    assign cell_ctl.last  = i_in.last_step;
    assign cell_ctl.shift = pop;

    always_comb begin
        n_left = r_left;
        if (accept && i_in.last_step) begin
            n_left = CNT_W'(TILE_ROWS);
        end else if (pop) begin
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    assign a_rows[0]  = i_in.a_row0;
    assign a_rows[1]  = i_in.a_row1;
    assign a_rows[2]  = i_in.a_row2;
    assign a_rows[3]  = i_in.a_row3;
    assign b_lanes[0] = i_in.b_lane0;
    assign b_lanes[1] = i_in.b_lane1;
    assign b_lanes[2] = i_in.b_lane2;
    assign b_lanes[3] = i_in.b_lane3;

    assign drain[TILE_ROWS] = '{default: '0};

    for (genvar r = 0; r < TILE_ROWS; r++) begin : g_cell
        opmb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_lane_mask  (lane_mask),
            .i_a          (a_rows[r]),
            .i_b          (b_lanes),
            .i_drain_next (drain[r+1]),
            .o_drain      (drain[r])
        );
    end

    assign o_out.valid    = r_left != '0;
    assign o_out.tile_row = ROW_W'(CNT_W'(TILE_ROWS) - r_left);
    assign o_out.last_row = r_left == CNT_W'(1);
    assign o_out.c_lane0  = drain[0][0];
    assign o_out.c_lane1  = drain[0][1];
    assign o_out.c_lane2  = drain[0][2];
    assign o_out.c_lane3  = drain[0][3];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Outer-product matmul block testbench
// Drives step items with random gaps and back-pressure. A directed table runs
// first, then random tiles under several column counts. Every emitted row is
// checked against want if typed, else an accumulator model of the 4 x 4 tile.
// ----------------------------------------------------------------------------
module testbench;
    import opmb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 16;
    localparam int HOLD_CYCLES    = 80;

    typedef enum logic {VEC_STEP, VEC_CFG} t_vec_op;

    // One row of the directed table. Operands are packed row3..row0 and
    // lane3..lane0, 16 bits each. When typed is set, every active lane of
    // every emitted row must equal want.
    typedef struct packed {
        t_vec_op          op;
        logic [CFG_W-1:0] cols;
        logic [63:0]      a;
        logic [63:0]      b;
        logic             last;
        logic             typed;
        t_acc             want;
    } t_vec;

    typedef struct packed {
        logic [ROW_W-1:0]            row;
        t_acc [TILE_LANES-1:0]       lane;
        logic                        last;
    } t_tile_row;

    localparam t_vec DIRECTED [25] = '{
        '{VEC_STEP, 3'd0, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
          1'b1, 1'b1, 48'h0000_0000_0000},
        '{VEC_STEP, 3'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
          1'b1, 1'b1, 48'h0000_4000_0000},
        '{VEC_STEP, 3'd0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
          1'b1, 1'b1, 48'hFFFF_C000_8000},
        '{VEC_STEP, 3'd0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
          1'b1, 1'b1, 48'h0000_3FFF_0001},
        '{VEC_STEP, 3'd0, 64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000,
          1'b1, 1'b1, 48'h0000_0100_0000},
        '{VEC_STEP, 3'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
          1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
          1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
          1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
          1'b1, 1'b1, 48'h0001_0000_0000},
        '{VEC_STEP, 3'd0, 64'h7FFF_F000_2000_1000, 64'h8000_1234_FFFF_0001,
          1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h8001_0001_FFFF_7FFE, 64'h0FFF_7FFF_8000_ABCD,
          1'b1, 1'b0, 48'h0},
        '{VEC_CFG,  3'd0, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
          1'b1, 1'b1, 48'h0000_0000_0000},
        '{VEC_CFG,  3'd7, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
          1'b1, 1'b1, 48'h0000_4000_0000},
        '{VEC_CFG,  3'd1, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321,
          1'b1, 1'b0, 48'h0},
        '{VEC_CFG,  3'd2, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h7FFF_8000_0001_FFFF, 64'h7FFF_8000_0001_FFFF,
          1'b0, 1'b0, 48'h0},
        '{VEC_CFG,  3'd4, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h0800_F800_4000_C000, 64'h2000_E000_7FFF_8001,
          1'b1, 1'b0, 48'h0},
        '{VEC_CFG,  3'd3, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'h5555_AAAA_3333_CCCC, 64'hAAAA_5555_CCCC_3333,
          1'b1, 1'b0, 48'h0},
        '{VEC_CFG,  3'd5, 64'h0, 64'h0, 1'b0, 1'b0, 48'h0},
        '{VEC_STEP, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_8000_8000_8000,
          1'b1, 1'b1, 48'h0000_0000_8000}
    };

    logic clk;
    logic rst_n;

    opmb_in_if  in_ch();
    opmb_out_if out_ch();
    opmb_cfg_if cfg_ch();

    outer_product_matmul_block_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Accumulator model of the tile and the rows it still owes.
    t_acc             acc_tile [TILE_ROWS][TILE_LANES];
    logic [CFG_W-1:0] column_count;
    t_tile_row        rows_due [$];

    // Side information that travels with the item on the input channel.
    logic             in_typed;
    t_acc             in_want;

    int               mismatches;
    int               idle_cycles;
    int               tx_idle_pct;
    int               rx_idle_pct;
    int               hold_request;
    int               hold_left;
    int               tile_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Folds the accepted item into the model and queues the rows it closes.
    task automatic fold_step();
        t_data     a_in [TILE_ROWS];
        t_data     b_in [TILE_LANES];
        t_acc      prod;
        t_tile_row due;
        a_in = '{in_ch.a_row0, in_ch.a_row1, in_ch.a_row2, in_ch.a_row3};
        b_in = '{in_ch.b_lane0, in_ch.b_lane1, in_ch.b_lane2, in_ch.b_lane3};
        for (int r = 0; r < TILE_ROWS; r++) begin
            for (int l = 0; l < TILE_LANES; l++) begin
                if (l < column_count) begin
                    prod = t_acc'(a_in[r]) * t_acc'(b_in[l]);
                    acc_tile[r][l] = acc_tile[r][l] + prod;
                end
            end
        end
        if (in_ch.last_step) begin
            for (int r = 0; r < TILE_ROWS; r++) begin
                due.row  = ROW_W'(r);
                due.last = (r == TILE_ROWS - 1);
                for (int l = 0; l < TILE_LANES; l++) begin
                    if (l >= column_count) due.lane[l] = '0;
                    else if (in_typed)     due.lane[l] = in_want;
                    else                   due.lane[l] = acc_tile[r][l];
                    acc_tile[r][l] = '0;
                end
                rows_due.push_back(due);
            end
        end
    endtask

    task automatic check_row();
        t_acc      got_lane [TILE_LANES];
        t_tile_row due;
        got_lane = '{out_ch.c_lane0, out_ch.c_lane1, out_ch.c_lane2, out_ch.c_lane3};
        if (rows_due.size() == 0) begin
            report_mismatch($sformatf("result row %0d with nothing expected",
                                      out_ch.tile_row));
        end else begin
            due = rows_due.pop_front();
            if (out_ch.tile_row !== due.row)
                report_mismatch($sformatf("tile_row got %0d expected %0d",
                                          out_ch.tile_row, due.row));
            for (int l = 0; l < TILE_LANES; l++) begin
                if (got_lane[l] !== due.lane[l])
                    report_mismatch($sformatf("row %0d c_lane%0d got %h expected %h",
                                              due.row, l, got_lane[l], due.lane[l]));
            end
            if (out_ch.last_row !== due.last)
                report_mismatch($sformatf("row %0d last_row got %b expected %b",
                                          due.row, out_ch.last_row, due.last));
        end
    endtask

    // Everything accepted at a rising edge is handled here, results first.
    always @(posedge clk) begin : monitor
        logic moved;
        moved = 1'b0;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                check_row();
            end
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                fold_step();
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                column_count = cfg_ch.data;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result receiver: random stalls, or a long hold when one is requested.
    initial begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!rst_n) begin
                out_ch.ready = 1'b0;
            end else if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic t_data pick_operand();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return t_data'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [63:0] random_operands();
        return {pick_operand(), pick_operand(), pick_operand(), pick_operand()};
    endfunction

    task automatic send_step(input logic [63:0] a, input logic [63:0] b,
                             input logic last, input logic typed, input t_acc want);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.a_row0    = a[15:0];
        in_ch.a_row1    = a[31:16];
        in_ch.a_row2    = a[47:32];
        in_ch.a_row3    = a[63:48];
        in_ch.b_lane0   = b[15:0];
        in_ch.b_lane1   = b[31:16];
        in_ch.b_lane2   = b[47:32];
        in_ch.b_lane3   = b[63:48];
        in_ch.last_step = last;
        in_typed        = typed;
        in_want         = want;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Random tiles: mostly short, now and then a long one. A tile may span a
    // phase boundary, so the column count can change in the middle of it.
    task automatic send_random_step();
        if (tile_left == 0)
            tile_left = ($urandom_range(9) == 0) ? $urandom_range(7, 24)
                                                 : $urandom_range(1, 4);
        send_step(random_operands(), random_operands(), tile_left == 1, 1'b0, '0);
        tile_left--;
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (rows_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_columns(input logic [CFG_W-1:0] cols);
        wait_drained();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = cols;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.a_row0 = '0;
        in_ch.a_row1 = '0;
        in_ch.a_row2 = '0;
        in_ch.a_row3 = '0;
        in_ch.b_lane0 = '0;
        in_ch.b_lane1 = '0;
        in_ch.b_lane2 = '0;
        in_ch.b_lane3 = '0;
        in_ch.last_step = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = ACTIVE_COLUMNS_RESET;
        in_typed     = 1'b0;
        in_want      = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        hold_request = 0;
        tile_left    = 0;
        tx_idle_pct  = 15;
        rx_idle_pct  = 48;
        column_count = ACTIVE_COLUMNS_RESET;
        for (int r = 0; r < TILE_ROWS; r++)
            for (int l = 0; l < TILE_LANES; l++)
                acc_tile[r][l] = '0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].op == VEC_CFG)
                write_columns(DIRECTED[i].cols);
            else
                send_step(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].last,
                          DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Hold the result side off while one-step tiles keep arriving, so the
        // block backs up into its input, then let it drain completely.
        write_columns(3'd4);
        hold_request = HOLD_CYCLES;
        repeat (12) send_step(random_operands(), random_operands(), 1'b1, 1'b0, '0);
        wait_drained();

        for (int regime = 0; regime < 3; regime++) begin
            tx_idle_pct = (regime == 0) ? 15 : (regime == 1) ? 48 : 0;
            rx_idle_pct = (regime == 0) ? 48 : (regime == 1) ? 15 : 0;
            for (int phase = 0; phase < 4; phase++) begin
                case (phase)
                    0:       write_columns(3'd4);
                    1:       write_columns(3'(regime == 1 ? 0 : 7));
                    default: write_columns(3'($urandom_range(7)));
                endcase
                repeat ($urandom_range(30, 38)) send_random_step();
            end
        end

        // Close any open tile so its rows are checked as well.
        write_columns(3'd4);
        while (tile_left != 0) send_random_step();

        wait_drained();
        repeat (END_CYCLES) @(negedge clk);
        if (mismatches == 0 && rows_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
